### rtl/hrfp_pkg.sv
// shared types, constants and the digit decode for the hex record parser
package hrfp_pkg;

    localparam logic [7:0]  CHAR_COLON  = 8'd58;
    localparam logic [7:0]  CHAR_ZERO   = 8'd48;
    localparam logic [7:0]  CHAR_FOUR   = 8'd52;
    localparam logic [7:0]  CHAR_NINE   = 8'd57;
    localparam logic [7:0]  DIGIT_BASE  = 8'd48;
    localparam logic [7:0]  LETTER_BASE = 8'd55;

    localparam int unsigned POS_W       = 11;
    localparam logic [POS_W-1:0] POS_MAX   = 11'd2047;
    localparam logic [POS_W-1:0] POS_COUNT = 11'd2;
    localparam logic [POS_W-1:0] POS_LOW   = 11'd6;
    localparam logic [POS_W-1:0] POS_TYPE  = 11'd8;
    localparam logic [POS_W-1:0] POS_DATA  = 11'd12;

    localparam logic [3:0]  TYPE_DATA   = 4'd0;
    localparam logic [3:0]  TYPE_UPPER  = 4'd4;
    localparam logic [3:0]  TYPE_OTHER  = 4'd15;

    localparam logic [15:0] UPPER_RESET = 16'h0800;
    localparam logic [7:0]  COUNT_MIN_UPPER = 8'd2;

    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

    typedef enum logic [2:0] {
        OP_COLON,
        OP_COUNT,
        OP_LOW,
        OP_TYPE,
        OP_GRP_FIRST,
        OP_GRP,
        OP_ACC
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] nib;
    } t_item;

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                d = c - DIGIT_BASE;
            end else begin
                d = c - LETTER_BASE;
            end
            return d[3:0];
        end
    endfunction

endpackage

### rtl/hrfp_front.sv
// front part: tracks record framing and character position, classifies each character
module hrfp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_char_code,
    output logic                 o_push,
    output hrfp_pkg::t_item      o_item
);
    import hrfp_pkg::*;

    logic             r_in_record, n_in_record;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             is_colon;

    assign is_colon = (i_char_code == CHAR_COLON);

    always_comb begin
        n_in_record = r_in_record;
        n_pos       = r_pos;
        o_push      = 1'b0;
        o_item.op   = OP_ACC;
        o_item.nib  = nibble_of(i_char_code);
        if (i_accept) begin
            if (is_colon) begin
                n_in_record = 1'b1;
                n_pos       = '0;
                o_push      = 1'b1;
                o_item.op   = OP_COLON;
            end else if (r_in_record) begin
                if (r_pos < POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
                o_push = 1'b1;
                if (n_pos == POS_COUNT) begin
                    o_item.op = OP_COUNT;
                end else if (n_pos == POS_LOW) begin
                    o_item.op = OP_LOW;
                end else if (n_pos == POS_TYPE) begin
                    o_item.op = OP_TYPE;
                    // type character reduced to its class
                    if (i_char_code == CHAR_ZERO) begin
                        o_item.nib = TYPE_DATA;
                    end else if (i_char_code == CHAR_FOUR) begin
                        o_item.nib = TYPE_UPPER;
                    end else begin
                        o_item.nib = TYPE_OTHER;
                    end
                end else if (n_pos == POS_DATA) begin
                    o_item.op = OP_GRP_FIRST;
                end else if (n_pos > POS_DATA && n_pos[1:0] == 2'b00) begin
                    o_item.op = OP_GRP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_record <= 1'b0;
            r_pos       <= '0;
        end else begin
            r_in_record <= n_in_record;
            r_pos       <= n_pos;
        end
    end

endmodule

### rtl/hrfp_queue.sv
// short queue of classified characters between front and back
module hrfp_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hrfp_pkg::t_item      i_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output hrfp_pkg::t_item      o_head,
    output logic                 o_nempty
);
    import hrfp_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;
    logic                do_pop;

    assign o_full   = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_nempty = (r_count != '0);
    assign o_head   = r_mem[r_rd_ptr];
    assign do_pop   = i_pop && o_nempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/hrfp_back.sv
// back part: record fields, digit accumulator and the flash write output register
module hrfp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_nempty,
    input  hrfp_pkg::t_item      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [31:0]          o_write_address,
    output logic [15:0]          o_write_halfword
);
    import hrfp_pkg::*;

    logic [7:0]  r_count, n_count;
    logic [3:0]  r_type, n_type;
    logic [15:0] r_low, n_low;
    logic [15:0] r_upper, n_upper;
    logic [11:0] r_acc, n_acc;
    logic [6:0]  r_hw, n_hw;
    logic        r_out_valid;
    logic [31:0] r_addr;
    logic [15:0] r_half;
    logic [15:0] word;
    logic        emit;

    assign o_pop = i_nempty && (!r_out_valid || !i_out_stall);
    assign word  = {r_acc, i_head.nib};

    always_comb begin
        n_count = r_count;
        n_type  = r_type;
        n_low   = r_low;
        n_upper = r_upper;
        n_acc   = r_acc;
        n_hw    = r_hw;
        emit    = 1'b0;
        if (o_pop) begin
            unique case (i_head.op)
                OP_COLON: begin
                    n_acc = '0;
                    n_hw  = '0;
                end
                OP_COUNT: begin
                    n_count = word[7:0];
                    n_acc   = '0;
                end
                OP_LOW: begin
                    n_low = word;
                    n_acc = '0;
                end
                OP_TYPE: begin
                    n_type = i_head.nib;
                    n_acc  = '0;
                end
                OP_GRP_FIRST, OP_GRP: begin
                    n_acc = '0;
                    if (r_type == TYPE_UPPER) begin
                        if (i_head.op == OP_GRP_FIRST && r_count >= COUNT_MIN_UPPER) begin
                            n_upper = word;
                        end
                    end else if (r_type == TYPE_DATA && r_hw < r_count[7:1]) begin
                        emit = 1'b1;
                        n_hw = r_hw + 1'b1;
                    end
                end
                OP_ACC: begin
                    n_acc = word[11:0];
                end
                default: begin
                    n_acc = r_acc;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_type      <= TYPE_DATA;
            r_low       <= '0;
            r_upper     <= UPPER_RESET;
            r_acc       <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_type  <= n_type;
            r_low   <= n_low;
            r_upper <= n_upper;
            r_acc   <= n_acc;
            r_hw    <= n_hw;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_addr <= {r_upper, r_low} + {24'd0, r_hw, 1'b0};
            r_half <= {word[7:0], word[15:8]};
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_address  = r_addr;
    assign o_write_halfword = r_half;

endmodule

### rtl/hex_record_flash_parser_core.sv
// top level of the hex record parser: front, queue and back
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+---------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_char_code
//  out     | output    | o_out_valid / i_out_stall | o_write_address, o_write_halfword
//
//  one character is taken per cycle while o_in_stall is low; after its last data
//  digit is taken, a flash write passes the queue entry, then the output register
//  the four-entry queue between front and back sets how far input runs ahead
//  o_in_stall rises only while that queue is full
//  a stalled output holds its write; the back keeps draining the queue only
//  while the output register is free or being taken
//  synchronous active-low reset, upper address returns to 0x0800
module hex_record_flash_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_write_address,
    output logic [15:0] o_write_halfword
);
    import hrfp_pkg::*;

    logic  accept;
    logic  push;
    t_item push_item;
    logic  full;
    logic  pop;
    t_item head;
    logic  nempty;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    hrfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .o_push      (push),
        .o_item      (push_item)
    );

    hrfp_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .o_full   (full),
        .i_pop    (pop),
        .o_head   (head),
        .o_nempty (nempty)
    );

    hrfp_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_nempty         (nempty),
        .i_head           (head),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_write_address  (o_write_address),
        .o_write_halfword (o_write_halfword)
    );

endmodule

### rtl/hrfp_checker.sv
// port-level checks for the hex record parser and their binding
module hrfp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_write_address,
    input logic [15:0] o_write_halfword
);

    // a stalled write stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transfer dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_write_address) && $stable(o_write_halfword))
        else $error("output payload changed while stalled");

    // reset empties the queue and the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset did not clear handshake state");

    // no write can appear so soon after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n ##1 1'b1 |=> !o_out_valid)
        else $error("write too soon after reset");

    // the queue only fills after an input transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid && !o_in_stall))
        else $error("input stall without a preceding transfer");

endmodule

bind hex_record_flash_parser_core hrfp_checker u_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_write_address  (o_write_address),
    .o_write_halfword (o_write_halfword)
);

### tb/tb_hex_record_flash_parser_core.sv
// self-checking testbench for the hex record flash parser core
module tb_hex_record_flash_parser_core;
    import hrfp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_ITEMS   = 120;
    localparam int RANDOM_CHARS = 850;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_LINES = 40;

    typedef enum int {REC_DATA, REC_UPPER, REC_OTHER, REC_BROKEN} rec_kind_e;

    typedef struct packed {
        logic [7:0] ch;
        logic       hold;
    } char_slot_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] half;
    } flash_write_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_char_code = 8'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_write_address;
    logic [15:0] o_write_halfword;

    hex_record_flash_parser_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_char_code      (i_char_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_write_address  (o_write_address),
        .o_write_halfword (o_write_halfword)
    );

    char_slot_t   char_queue[$];
    flash_write_t flash_writes[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int chars_sent    = 0;
    int writes_checked = 0;
    int gap_left      = 0;
    int stall_left    = 0;
    int rec_tally[4]  = '{0, 0, 0, 0};

    // parser state as the testbench sees it
    logic             rec_open   = 1'b0;
    logic [POS_W-1:0] rec_pos    = '0;
    logic [7:0]       rec_count  = 8'd0;
    logic [3:0]       rec_kind   = TYPE_DATA;
    logic [15:0]      low_addr   = 16'd0;
    logic [15:0]      upper_addr = UPPER_RESET;
    logic [11:0]      digit_acc  = 12'd0;
    logic [6:0]       half_idx   = 7'd0;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= REPORT_LINES)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
    endtask

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            d = c - DIGIT_BASE;
        else
            d = c - LETTER_BASE;
        return d[3:0];
    endfunction

    task automatic parse_flash_char(input logic [7:0] c);
        logic [3:0]   nib;
        logic [15:0]  word;
        flash_write_t fw;
        if (c == CHAR_COLON) begin
            rec_open  = 1'b1;
            rec_pos   = '0;
            digit_acc = '0;
            half_idx  = '0;
            return;
        end
        if (!rec_open)
            return;
        if (rec_pos < POS_MAX)
            rec_pos = rec_pos + 1'b1;
        nib  = hex_nibble(c);
        word = {digit_acc, nib};
        if (rec_pos == POS_COUNT) begin
            rec_count = word[7:0];
            digit_acc = '0;
        end else if (rec_pos == POS_LOW) begin
            low_addr  = word;
            digit_acc = '0;
        end else if (rec_pos == POS_TYPE) begin
            if (c == CHAR_ZERO)
                rec_kind = TYPE_DATA;
            else if (c == CHAR_FOUR)
                rec_kind = TYPE_UPPER;
            else
                rec_kind = TYPE_OTHER;
            digit_acc = '0;
        end else if (rec_pos >= POS_DATA && rec_pos[1:0] == 2'b00) begin
            digit_acc = '0;
            if (rec_kind == TYPE_UPPER) begin
                if (rec_pos == POS_DATA && rec_count >= COUNT_MIN_UPPER)
                    upper_addr = word;
            end else if (rec_kind == TYPE_DATA && {1'b0, half_idx} < (rec_count >> 1)) begin
                fw.addr = {upper_addr, low_addr} + {24'd0, half_idx, 1'b0};
                fw.half = {word[7:0], word[15:8]};
                flash_writes.push_back(fw);
                half_idx = half_idx + 1'b1;
            end
        end else begin
            digit_acc = word[11:0];
        end
    endtask

    task automatic push_char(input logic [7:0] c);
        char_slot_t s;
        s.ch   = c;
        s.hold = 1'b0;
        char_queue.push_back(s);
    endtask

    // sender waits here until every outstanding write has come back
    task automatic push_hold();
        char_slot_t s;
        s.ch   = 8'd0;
        s.hold = 1'b1;
        char_queue.push_back(s);
    endtask

    // lower-case letters decode the same as upper-case
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CHAR_ZERO + n;
        if ($urandom_range(0, 1) != 0)
            return 8'd97 + n - 8'd10;
        return 8'd65 + n - 8'd10;
    endfunction

    function automatic logic [7:0] any_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == CHAR_COLON)
            c = 8'd59;
        return c;
    endfunction

    function automatic logic [7:0] data_char();
        if ($urandom_range(0, 19) == 0)
            return any_char();
        return hex_char(4'($urandom_range(0, 15)));
    endfunction

    task automatic push_hex(input logic [15:0] value, input int digits);
        for (int i = digits - 1; i >= 0; i--)
            push_char(hex_char(value[4*i +: 4]));
    endtask

    task automatic add_record(input rec_kind_e kind);
        logic [7:0]  count;
        logic [15:0] addr;
        logic [15:0] upper;
        int          n_digits;
        int          r;
        rec_tally[kind]++;
        push_char(CHAR_COLON);
        if (kind == REC_BROKEN) begin
            repeat ($urandom_range(0, 9)) begin
                if ($urandom_range(0, 1) != 0)
                    push_char(any_char());
                else
                    push_char(hex_char(4'($urandom_range(0, 15))));
            end
            return;
        end
        r = $urandom_range(0, 9);
        if (kind == REC_UPPER)
            count = (r < 8) ? 8'd2 : 8'($urandom_range(0, 3));
        else if (r == 0)
            count = 8'd0;
        else if (r == 1)
            count = 8'($urandom_range(17, 255));
        else
            count = 8'($urandom_range(1, 16));
        r = $urandom_range(0, 9);
        if (r == 0)
            addr = 16'hFFF0 | 16'($urandom_range(0, 15));
        else if (r == 1)
            addr = 16'h0000;
        else
            addr = 16'($urandom_range(0, 65535));
        push_hex({8'd0, count}, 2);
        push_hex(addr, 4);
        push_char(($urandom_range(0, 9) == 0) ? hex_char(4'($urandom_range(0, 15))) : CHAR_ZERO);
        case (kind)
            REC_DATA: push_char(CHAR_ZERO);
            REC_UPPER: push_char(CHAR_FOUR);
            default: begin
                r = $urandom_range(0, 4);
                if (r == 0)
                    push_char(any_char() == CHAR_ZERO ? 8'd49 : 8'd53);
                else
                    push_char(8'(CHAR_ZERO + r + ((r >= 4) ? 1 : 0)));
            end
        endcase
        n_digits = 2 * count;
        if (kind == REC_UPPER && count >= COUNT_MIN_UPPER) begin
            r = $urandom_range(0, 3);
            upper = (r == 0) ? 16'hFFFF : (r == 1) ? 16'h0000 : 16'($urandom_range(0, 65535));
            push_hex(upper, 4);
            n_digits = n_digits - 4;
        end else begin
            if (n_digits > 40)
                n_digits = $urandom_range(8, 40);
            r = $urandom_range(0, 7);
            if (r == 0)
                n_digits = $urandom_range(0, n_digits);
            else if (r == 1)
                n_digits = n_digits + $urandom_range(1, 9);
        end
        repeat (n_digits) push_char(data_char());
        push_hex(16'($urandom_range(0, 255)), 2);
        if ($urandom_range(0, 1) != 0) begin
            push_char(8'd13);
            push_char(8'd10);
        end
    endtask

    task automatic build_stimulus();
        string     lead;
        int        quota;
        int        r;
        bit        mid_hold;
        // ignored before the first record
        push_char(8'h5A);
        push_char(8'hFF);
        push_char(8'h00);
        lead = ":020000041FFF:02F0FE00A5z~:01FFFF041234:00000001FF";
        for (int i = 0; i < lead.len(); i++)
            push_char(lead[i]);
        push_hold();
        mid_hold = 1'b0;
        quota = char_queue.size() + RANDOM_CHARS;
        while (char_queue.size() < quota) begin
            if (!mid_hold && char_queue.size() > quota - RANDOM_CHARS / 2) begin
                push_hold();
                mid_hold = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 68)
                add_record(REC_DATA);
            else if (r < 80)
                add_record(REC_UPPER);
            else if (r < 90)
                add_record(REC_OTHER);
            else
                add_record(REC_BROKEN);
        end
    endtask

    always @(posedge i_clk) begin : char_driver
        logic       took;
        char_slot_t slot;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            took = i_in_valid && !o_in_stall;
            if (took) begin
                parse_flash_char(i_char_code);
                chars_sent++;
            end
            if (!i_in_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (char_queue.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (char_queue[0].hold) begin
                    i_in_valid <= 1'b0;
                    if (flash_writes.size() == 0)
                        slot = char_queue.pop_front();
                end else if (char_queue.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                    gap_left = $urandom_range(0, 5);
                    i_in_valid <= 1'b0;
                end else begin
                    slot = char_queue.pop_front();
                    i_char_code <= slot.ch;
                    i_in_valid  <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : write_monitor
        flash_write_t want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (flash_writes.size() == 0) begin
                    report_mismatch($sformatf("unexpected write %h <- %h",
                                              o_write_address, o_write_halfword));
                end else begin
                    want = flash_writes.pop_front();
                    writes_checked++;
                    if (o_write_address !== want.addr)
                        report_mismatch($sformatf("address %h, predicted %h",
                                                  o_write_address, want.addr));
                    if (o_write_halfword !== want.half)
                        report_mismatch($sformatf("halfword %h, predicted %h at %h",
                                                  o_write_halfword, want.half, want.addr));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (char_queue.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 5);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d writes outstanding", flash_writes.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (char_queue.size() != 0 || i_in_valid)
            @(posedge i_clk);
        while (flash_writes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("%0d characters: %0d data, %0d upper-address, %0d other-type, %0d cut-off records",
                 chars_sent, rec_tally[REC_DATA], rec_tally[REC_UPPER], rec_tally[REC_OTHER],
                 rec_tally[REC_BROKEN]);
        $display("%0d flash writes compared, sender drained twice mid-run, %0d errors",
                 writes_checked, error_count);
        if (error_count == 0 && flash_writes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### hex_record_flash_parser_core.f
rtl/hrfp_pkg.sv
rtl/hrfp_front.sv
rtl/hrfp_queue.sv
rtl/hrfp_back.sv
rtl/hex_record_flash_parser_core.sv
rtl/hrfp_checker.sv
tb/tb_hex_record_flash_parser_core.sv
